// File: hw/rtl/isolated_pixel_counter_assert.svh
// assertion macros for the isolated pixel counter
// no dependencies; included by the top level
`ifndef ISOLATED_PIXEL_COUNTER_ASSERT_SVH
`define ISOLATED_PIXEL_COUNTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define IPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define IPC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/ipc_pkg.sv
// shared types, constants and the flag cancel function of the isolated pixel counter
// no dependencies
package ipc_pkg;

  localparam int POS_W     = 10;
  localparam int CFG_W     = 11;
  localparam int COUNT_W   = 21;
  localparam int ROW_LIMIT = 1024;

  typedef enum logic {
    REG_FRAME_COLUMNS = 1'b0,
    REG_FRAME_ROWS    = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic cand;
    logic set;
  } flags_t;

  typedef struct packed {
    logic advance;
    logic hit;
    logic use_q;
    logic active;
  } cell_ctrl_t;

  function automatic flags_t flags_cancel(flags_t view, logic hit, logic active);
    flags_t kept;
    kept.set  = view.set;
    kept.cand = view.cand & ~(hit & active);
    return kept;
  endfunction

endpackage

// File: hw/rtl/ipc_ram.sv
// generic simple ram: one write port, two read ports, registered read
// no dependencies
module ipc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/ipc_cell.sv
// one neighbor cell of the window: holds a flag pair, cancels its candidate on a hit
// depends on ipc_pkg
module ipc_cell (
  input  logic               clk,
  input  ipc_pkg::cell_ctrl_t ctrl,
  input  ipc_pkg::flags_t    ext,
  input  ipc_pkg::flags_t    d,
  output ipc_pkg::flags_t    q,
  output ipc_pkg::flags_t    kept,
  output logic               view_set,
  output logic               dropped
);
  import ipc_pkg::*;

  flags_t view;

  assign view     = ctrl.use_q ? q : ext;
  assign kept     = flags_cancel(view, ctrl.hit, ctrl.active);
  assign view_set = ctrl.active & view.set;
  assign dropped  = ctrl.active & ctrl.hit & view.cand;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      q <= d;
    end
  end

endmodule

// File: hw/rtl/isolated_pixel_counter.sv
// Isolated pixel counter, top level: position tracking, line buffer, window cells, count.
// Depends on ipc_pkg, ipc_ram, ipc_cell and isolated_pixel_counter_assert.svh.
//
// Takes one pixel per cycle in row-major order while pixel_stall is low and, on the
// last pixel of each frame, delivers the number of set pixels with no set 8-neighbor.
// A pixel beat is accepted in any cycle without pixel_stall; a result passes the line
// buffer's registered read into stage 1, then the window and count update into the result
// register. The pixel side stalls only while a frame result is ready and the previous one
// is still held in the output register. No clearing pass is needed after reset.
`include "isolated_pixel_counter_assert.svh"

module isolated_pixel_counter #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  logic                        pixel_set,
  output logic                        count_valid,
  input  logic                        count_stall,
  output logic [ipc_pkg::COUNT_W-1:0] isolated_count,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [ipc_pkg::CFG_W-1:0]   cfg_data
);
  import ipc_pkg::*;

  localparam int AW    = $clog2(MAX_COLUMNS);
  localparam int MW    = $clog2(MAX_COLUMNS + 1);
  localparam int CMPA  = (MW > CFG_W) ? MW : CFG_W;
  localparam int CMPW  = (CMPA > POS_W) ? CMPA : POS_W;
  localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_COLUMNS);

  logic [CFG_W-1:0]   frame_columns;
  logic [CFG_W-1:0]   frame_rows;
  logic [POS_W-1:0]   column_position;
  logic [POS_W-1:0]   row_position;
  logic [COUNT_W-1:0] running_count;

  logic [CMPW-1:0]  cols_w;
  logic [CMPW-1:0]  cols_eff;
  logic [CFG_W-1:0] rows_eff;
  logic [CMPW-1:0]  c_ext;
  logic [CMPW-1:0]  c_eff;
  logic             row_end;
  logic             frame_end;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic [AW-1:0]    last_addr;
  logic             pixel_accept;

  logic          s1_valid;
  logic          s1_go;
  logic          s1_pix;
  logic          s1_first_col;
  logic          s1_upper;
  logic          s1_row_end;
  logic          s1_frame_end;
  logic [AW-1:0] s1_addr;
  logic          s1_hit_a;
  logic          s1_hit_b;
  logic          s1_cur_a;
  logic          s1_cur_b;
  flags_t        s1_fwd;

  logic          prev_valid;
  logic [AW-1:0] prev_addr;
  logic          we;
  logic [1:0]    ram_a;
  logic [1:0]    ram_b;

  flags_t     u_ext;
  flags_t     ur_view;
  flags_t     ur_kept;
  logic       ur_active;
  logic       ur_set;
  logic       ur_drop;
  flags_t     u_q;
  flags_t     u_kept;
  logic       u_set;
  logic       u_drop;
  flags_t     ul_q;
  logic       ul_set;
  logic       ul_drop;
  flags_t     left_q;
  flags_t     left_kept;
  logic       left_set;
  logic       left_drop;
  flags_t     cur;
  logic       any_set;
  logic [2:0] drops;
  logic [COUNT_W-1:0] count_next;
  cell_ctrl_t u_ctrl;
  cell_ctrl_t ul_ctrl;
  cell_ctrl_t left_ctrl;

  // position and limits
  always_comb begin
    cols_w = CMPW'(frame_columns);
    if (cols_w == '0) begin
      cols_eff = CMPW'(1);
    end else if (cols_w > MAX_C) begin
      cols_eff = MAX_C;
    end else begin
      cols_eff = cols_w;
    end
    if (frame_rows == '0) begin
      rows_eff = CFG_W'(1);
    end else if (frame_rows > CFG_W'(ROW_LIMIT)) begin
      rows_eff = CFG_W'(ROW_LIMIT);
    end else begin
      rows_eff = frame_rows;
    end
    c_ext     = CMPW'(column_position);
    c_eff     = (c_ext >= MAX_C) ? (MAX_C - CMPW'(1)) : c_ext;
    row_end   = (c_eff >= (cols_eff - CMPW'(1)));
    frame_end = row_end && (CFG_W'(row_position) >= (rows_eff - CFG_W'(1)));
    addr_a    = c_eff[AW-1:0];
    addr_b    = AW'(c_eff + CMPW'(1));
  end

  assign s1_go        = s1_valid && !(s1_frame_end && count_valid && count_stall);
  assign pixel_stall  = s1_valid && s1_frame_end && count_valid && count_stall;
  assign pixel_accept = pixel_valid && !pixel_stall;
  assign we           = s1_go && prev_valid;
  // column of the newest pixel, whose flags still sit in the left cell
  assign last_addr    = s1_valid ? s1_addr : prev_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_columns <= CFG_W'(1024);
      frame_rows    <= CFG_W'(1024);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_FRAME_COLUMNS: frame_columns <= cfg_data;
        REG_FRAME_ROWS:    frame_rows    <= cfg_data;
        default:           frame_rows    <= frame_rows;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (pixel_accept) begin
      if (frame_end) begin
        column_position <= '0;
        row_position    <= '0;
      end else if (row_end) begin
        column_position <= '0;
        row_position    <= row_position + POS_W'(1);
      end else begin
        column_position <= POS_W'(c_eff + CMPW'(1));
      end
    end
  end

  // stage 1 beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_pix       <= pixel_set;
      s1_first_col <= (c_eff == '0);
      s1_upper     <= (row_position != '0);
      s1_row_end   <= row_end;
      s1_frame_end <= frame_end;
      s1_addr      <= addr_a;
      s1_hit_a     <= we && (prev_addr == addr_a);
      s1_hit_b     <= we && (prev_addr == addr_b);
      // previous row's last pixel not yet in the line
      s1_cur_a     <= (s1_valid || prev_valid) && (c_eff == '0) && (last_addr == addr_a);
      s1_cur_b     <= (s1_valid || prev_valid) && (c_eff == '0) && (last_addr == addr_b);
      s1_fwd       <= left_kept;
    end
  end

  // delayed write of the left pixel, or of the row's last pixel at the next row start
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
    end else if (s1_go) begin
      prev_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      prev_addr <= s1_addr;
    end
  end

  ipc_ram #(
    .WIDTH(2),
    .DEPTH(MAX_COLUMNS)
  ) u_line (
    .clk     (clk),
    .we      (we),
    .waddr   (prev_addr),
    .wdata   (left_kept),
    .re      (pixel_accept),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // window: upper-right from the line, then upper, upper-left, and left
  always_comb begin
    u_ext     = s1_cur_a ? left_q : (s1_hit_a ? s1_fwd : flags_t'(ram_a));
    ur_view   = s1_cur_b ? left_q : (s1_hit_b ? s1_fwd : flags_t'(ram_b));
    ur_active = s1_upper && !s1_row_end;
    ur_kept   = flags_cancel(ur_view, s1_pix, ur_active);
    ur_set    = ur_active && ur_view.set;
    ur_drop   = ur_active && s1_pix && ur_view.cand;

    u_ctrl    = '{advance: s1_go, hit: s1_pix, use_q: !s1_first_col, active: s1_upper};
    ul_ctrl   = '{advance: s1_go, hit: s1_pix, use_q: 1'b1,
                  active: s1_upper && !s1_first_col};
    left_ctrl = '{advance: s1_go, hit: s1_pix, use_q: 1'b1, active: !s1_first_col};
  end

  ipc_cell u_cell_u (
    .clk      (clk),
    .ctrl     (u_ctrl),
    .ext      (u_ext),
    .d        (ur_kept),
    .q        (u_q),
    .kept     (u_kept),
    .view_set (u_set),
    .dropped  (u_drop)
  );

  ipc_cell u_cell_ul (
    .clk      (clk),
    .ctrl     (ul_ctrl),
    .ext      (u_q),
    .d        (u_kept),
    .q        (ul_q),
    .kept     (),
    .view_set (ul_set),
    .dropped  (ul_drop)
  );

  ipc_cell u_cell_left (
    .clk      (clk),
    .ctrl     (left_ctrl),
    .ext      (ul_q),
    .d        (cur),
    .q        (left_q),
    .kept     (left_kept),
    .view_set (left_set),
    .dropped  (left_drop)
  );

  always_comb begin
    any_set    = ur_set || u_set || ul_set || left_set;
    cur.set    = s1_pix;
    cur.cand   = s1_pix && !any_set;
    drops      = 3'(ur_drop) + 3'(u_drop) + 3'(ul_drop) + 3'(left_drop);
    count_next = running_count - COUNT_W'(drops) + COUNT_W'(cur.cand);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
    end else if (s1_go) begin
      running_count <= s1_frame_end ? '0 : count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (s1_go && s1_frame_end) begin
      count_valid <= 1'b1;
    end else if (!count_stall) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_frame_end) begin
      isolated_count <= count_next;
    end
  end

  `IPC_ASSERT_IMPLY(a_stall_only_on_held_result, clk, rst, pixel_stall, count_valid && count_stall)
  `IPC_ASSERT_NEXT(a_frame_end_gives_result, clk, rst, s1_go && s1_frame_end, count_valid)
  `IPC_ASSERT_NEXT(a_row_end_wraps_column, clk, rst, pixel_accept && row_end, column_position == '0)

endmodule
